>>> design/rkf78_pkg.sv
// ----------------------------------------------------------------------------
// rkf78_pkg
// Shared types, stage weights and rounding helpers for the stage combiner.
// ----------------------------------------------------------------------------
package rkf78_pkg;

  localparam int STAGE_NUM = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDK,
    ST_MULK,
    ST_WAITK,
    ST_RND,
    ST_WAITW,
    ST_FIN
  } fsm_t;

  typedef logic signed [63:0] q64_t;

  localparam logic [63:0] TWO33 = 64'd8589934592;

  // weight table, row is the stage, column the derivative (earlier stored ones, the diagonal the incoming one)
  localparam q64_t COEF [STAGE_NUM][STAGE_NUM] = '{
    '{(TWO33*2+27)/54, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{(TWO33*1+36)/72, (TWO33*1+12)/24, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{(TWO33*1+24)/48, 0, (TWO33*1+8)/16, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{(TWO33*5+12)/24, 0, 64'd0-(TWO33*25+16)/32, (TWO33*25+16)/32,
      0, 0, 0, 0, 0, 0, 0, 0},
    '{(TWO33*1+20)/40, 0, 0, (TWO33*1+4)/8, (TWO33*1+5)/10,
      0, 0, 0, 0, 0, 0, 0},
    '{64'd0-(TWO33*25+108)/216, 0, 0, (TWO33*125+108)/216,
      64'd0-(TWO33*65+27)/54, (TWO33*125+54)/108, 0, 0, 0, 0, 0, 0},
    '{(TWO33*31+300)/600, 0, 0, 0, (TWO33*61+225)/450,
      64'd0-(TWO33*2+9)/18, (TWO33*13+900)/1800, 0, 0, 0, 0, 0},
    '{(TWO33*2+1)/2, 0, 0, 64'd0-(TWO33*53+6)/12, (TWO33*704+45)/90,
      64'd0-(TWO33*107+9)/18, (TWO33*67+90)/180, (TWO33*3+1)/2, 0, 0, 0, 0},
    '{64'd0-(TWO33*91+108)/216, 0, 0, (TWO33*23+108)/216,
      64'd0-(TWO33*976+135)/270, (TWO33*311+54)/108,
      64'd0-(TWO33*19+60)/120, (TWO33*17+6)/12, 64'd0-(TWO33*1+12)/24,
      0, 0, 0},
    '{(TWO33*3+205)/410, 0, 0, 0, 0, 64'd0-(TWO33*6+41)/82,
      64'd0-(TWO33*3+205)/410, 64'd0-(TWO33*3+41)/82, (TWO33*3+41)/82,
      (TWO33*6+41)/82, 0, 0},
    '{64'd0-(TWO33*1777+4100)/8200, 0, 0, 64'd0-(TWO33*341+164)/328,
      (TWO33*4496+1025)/2050, 64'd0-(TWO33*289+82)/164,
      (TWO33*2193+4100)/8200, (TWO33*51+82)/164, (TWO33*33+164)/328,
      (TWO33*12+41)/82, (TWO33*1+1)/2, 0},
    '{0, 0, 0, 0, 0, (TWO33*34+105)/210, (TWO33*9+35)/70, (TWO33*9+35)/70,
      (TWO33*9+280)/560, (TWO33*9+280)/560, (TWO33*41+840)/1680,
      (TWO33*41+840)/1680}
  };

  function automatic logic [63:0] round_sat(input logic [127:0] x);
    logic [127:0] y;
    logic [31:0]  top;
    logic [63:0]  r;
    logic         fits;
    y    = x + 128'h8000_0000;
    top  = y[127:96];
    r    = y[95:32];
    fits = r[63] ? (top == 32'hFFFF_FFFF) : (top == 32'h0);
    if (!fits) begin
      round_sat = y[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      round_sat = r;
    end
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_add = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_add = s;
    end
  endfunction

endpackage

>>> design/rkf78_mul.sv
// ----------------------------------------------------------------------------
// rkf78_mul
// Signed 64 x 64 multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module rkf78_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0]  ma_r, mb_r;
  logic         neg_r, active_r, done_r;
  logic [2:0]   step_r;
  logic [127:0] acc_r, prod_r;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  assign pp = 64'(ma_r[{step_r[1], 5'b0} +: 32]) * 64'(mb_r[{step_r[0], 5'b0} +: 32]);

  always_comb begin
    case (step_r[1:0])
      2'd0:    pp_sh = {64'b0, pp};
      2'd3:    pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= active_r && !start && (step_r == 3'd4);
      if (start) begin
        ma_r     <= a[63] ? 64'd0 - a : a;
        mb_r     <= b[63] ? 64'd0 - b : b;
        neg_r    <= a[63] ^ b[63];
        acc_r    <= '0;
        step_r   <= '0;
        active_r <= 1'b1;
      end else if (active_r) begin
        if (step_r < 3'd4) begin
          acc_r  <= acc_r + pp_sh;
          step_r <= step_r + 3'd1;
        end else begin
          prod_r   <= neg_r ? 128'd0 - acc_r : acc_r;
          active_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

>>> design/rkf78_store.sv
// ----------------------------------------------------------------------------
// rkf78_store
// Base state memory and stage derivative memory, registered reads.
// ----------------------------------------------------------------------------
module rkf78_store #(
  parameter int AW = 6,
  parameter int DW = 10,
  parameter int BD = 64,
  parameter int DD = 704
) (
  input  logic          clk,
  input  logic          b_re,
  input  logic          b_we,
  input  logic [AW-1:0] b_addr,
  input  logic [63:0]   b_wdata,
  output logic [63:0]   b_rdata,
  input  logic          k_re,
  input  logic          k_we,
  input  logic [DW-1:0] k_addr,
  input  logic [63:0]   k_wdata,
  output logic [63:0]   k_rdata
);

  logic [63:0] base_mem [BD];
  logic [63:0] deriv_mem [DD];
  logic [63:0] b_rdata_r, k_rdata_r;

  always_ff @(posedge clk) begin
    if (b_we) begin
      base_mem[b_addr] <= b_wdata;
    end
    if (b_re) begin
      b_rdata_r <= base_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      deriv_mem[k_addr] <= k_wdata;
    end
    if (k_re) begin
      k_rdata_r <= deriv_mem[k_addr];
    end
  end

  assign b_rdata = b_rdata_r;
  assign k_rdata = k_rdata_r;

endmodule

>>> design/rkf78_stage_combiner_unit.sv
// ----------------------------------------------------------------------------
// rkf78_stage_combiner_unit
// RKF 7(8) stage combiner: weighted sum of stored stage derivatives per element.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_tvalid/in_tready    in_tdata
//  out      out  out_tvalid/out_tready  out_tdata
//  cfg      in   psel/penable/pready    paddr, pwdata, prdata
//
//  an item at stage s holds the block from the accept step to finish: each of
//  its s+1 terms takes a read step, a start step and a wait on the shared
//  multiplier, then a round step, a wait for the dt product, finish
//  one item is in flight; the next beat is taken once the block is idle
//  reset clears stage, saved time and out valid and loads config defaults; memories are not cleared
//  a stalled result waits in the output register, the finish step holds
// ----------------------------------------------------------------------------
module rkf78_stage_combiner_unit #(
  parameter int MAX_STATE = 64,
  parameter int STAGES    = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // element_index, deriv_value, start_state, start_time
  input  logic [199:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_index, stage_state, next_stage, end_time
  output logic [143:0] out_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int AW = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
  localparam int DD = (STAGES - 1) * MAX_STATE;
  localparam int DW = (DD > 1) ? $clog2(DD) : 1;
  localparam logic [3:0] ADDR_STEP  = 4'd0;
  localparam logic [3:0] ADDR_COUNT = 4'd8;

  rkf78_pkg::fsm_t state_r, state_nxt;

  logic [39:0] step_size_r;
  logic [6:0]  state_count_r;
  logic [3:0]  stage_r;
  logic [63:0] saved_time_r;

  logic [5:0]    idx_r;
  logic [AW-1:0] addr_r;
  logic [63:0]   dv_r;
  logic [3:0]    s_r, j_r;
  logic [DW-1:0] kaddr_r;
  logic [127:0]  acc_r;
  logic [63:0]  inc_r;

  logic          out_valid_r;
  logic [5:0]    out_idx_r;
  logic [63:0]   out_val_r, out_end_r;
  logic [3:0]    out_ns_r;

  logic          accept, out_free, cfg_wr;
  logic [5:0]    in_idx;
  logic [AW-1:0] in_addr;
  logic [6:0]    cnt_eff;
  logic [63:0]   val, b_rdata, k_rdata, mul_a, mul_b;
  logic          mul_start, mul_done, k_re, b_re, fin_go;
  logic [127:0]  mul_prod;
  logic [3:0]    s_next;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_tready = (state_r == rkf78_pkg::ST_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign in_idx   = in_tdata[5:0];

  // element index folded onto the store depth
  always_comb begin
    in_addr = '0;
    for (int i = 0; i < 64; i++) begin
      if (in_idx == 6'(i)) in_addr = AW'(i % MAX_STATE);
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_STEP:  prdata = {24'b0, step_size_r};
      ADDR_COUNT: prdata = {57'b0, state_count_r};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (state_count_r == 7'd0) begin
      cnt_eff = 7'd1;
    end else if (int'(state_count_r) > MAX_STATE) begin
      cnt_eff = 7'(MAX_STATE);
    end else begin
      cnt_eff = state_count_r;
    end
  end

  assign val    = rkf78_pkg::sat_add(b_rdata, inc_r);
  assign fin_go = (state_r == rkf78_pkg::ST_FIN) && out_free;
  assign s_next = ({1'b0, idx_r} == cnt_eff - 7'd1) ?
                  ((s_r == 4'(STAGES - 1)) ? 4'd0 : s_r + 4'd1) : s_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rkf78_pkg::ST_IDLE:  if (accept) state_nxt = rkf78_pkg::ST_RDK;
      rkf78_pkg::ST_RDK:   state_nxt = rkf78_pkg::ST_MULK;
      rkf78_pkg::ST_MULK:  state_nxt = rkf78_pkg::ST_WAITK;
      rkf78_pkg::ST_WAITK: begin
        if (mul_done) state_nxt = (j_r == s_r) ? rkf78_pkg::ST_RND : rkf78_pkg::ST_RDK;
      end
      rkf78_pkg::ST_RND:   state_nxt = rkf78_pkg::ST_WAITW;
      rkf78_pkg::ST_WAITW: if (mul_done) state_nxt = rkf78_pkg::ST_FIN;
      rkf78_pkg::ST_FIN:   if (out_free) state_nxt = rkf78_pkg::ST_IDLE;
      default:             state_nxt = rkf78_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    k_re      = 1'b0;
    b_re      = 1'b0;
    mul_start = 1'b0;
    mul_a     = dv_r;
    mul_b     = rkf78_pkg::COEF[s_r][j_r];
    unique case (state_r)
      rkf78_pkg::ST_RDK:  k_re = 1'b1;
      rkf78_pkg::ST_MULK: begin
        mul_start = 1'b1;
        mul_a     = (j_r == s_r) ? dv_r : k_rdata;
      end
      rkf78_pkg::ST_RND: begin
        mul_start = 1'b1;
        b_re      = 1'b1;
        mul_a     = rkf78_pkg::round_sat(acc_r);
        mul_b     = {24'b0, step_size_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rkf78_pkg::ST_IDLE;
      step_size_r   <= 40'd42949673;
      state_count_r <= 7'd64;
      stage_r       <= '0;
      saved_time_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr == ADDR_STEP) step_size_r <= pwdata[39:0];
      if (cfg_wr && paddr == ADDR_COUNT) state_count_r <= pwdata[6:0];
      if (accept && stage_r == 4'd0) saved_time_r <= in_tdata[197:134];
      out_valid_r <= fin_go || (out_valid_r && !out_tready);
      if (fin_go) begin
        stage_r <= s_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r   <= in_idx;
      addr_r  <= in_addr;
      dv_r    <= in_tdata[69:6];
      s_r     <= stage_r;
      j_r     <= '0;
      kaddr_r <= DW'(in_addr);
      acc_r   <= '0;
    end
    if (state_r == rkf78_pkg::ST_WAITK && mul_done) begin
      acc_r <= acc_r + mul_prod;
      if (j_r != s_r) begin
        j_r     <= j_r + 4'd1;
        kaddr_r <= kaddr_r + DW'(MAX_STATE);
      end
    end
    if (state_r == rkf78_pkg::ST_WAITW && mul_done) begin
      inc_r <= rkf78_pkg::round_sat(mul_prod);
    end
    if (fin_go) begin
      out_idx_r <= idx_r;
      out_val_r <= val;
      out_ns_r  <= s_next;
      out_end_r <= (s_r == 4'(STAGES - 1)) ?
                   rkf78_pkg::sat_add(saved_time_r, {24'b0, step_size_r}) : 64'd0;
    end
  end

  rkf78_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rkf78_store #(
    .AW (AW),
    .DW (DW),
    .BD (MAX_STATE),
    .DD (DD)
  ) u_store (
    .clk     (clk),
    .b_re    (b_re),
    .b_we    ((accept && stage_r == 4'd0) || (fin_go && s_r == 4'(STAGES - 1))),
    .b_addr  (accept ? in_addr : addr_r),
    .b_wdata (accept ? in_tdata[133:70] : val),
    .b_rdata (b_rdata),
    .k_re    (k_re),
    .k_we    (fin_go && s_r != 4'(STAGES - 1)),
    .k_addr  (kaddr_r),
    .k_wdata (dv_r),
    .k_rdata (k_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_end_r, out_ns_r, out_val_r, out_idx_r};

endmodule
